@@ sv/sircs_pkg.sv @@
package sircs_pkg;

   // command codes on the request channel
   localparam logic [1:0] FUNC_EDGE  = 2'd0;
   localparam logic [1:0] FUNC_POP   = 2'd1;
   localparam logic [1:0] FUNC_FLUSH = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_START_MARK   = 3'd0;
   localparam logic [2:0] CSR_SPACE        = 3'd1;
   localparam logic [2:0] CSR_ONE_MARK     = 3'd2;
   localparam logic [2:0] CSR_ZERO_MARK    = 3'd3;
   localparam logic [2:0] CSR_TOLERANCE    = 3'd4;
   localparam logic [2:0] CSR_INTERKEY     = 3'd5;
   localparam logic [2:0] CSR_RESET_KEY    = 3'd6;
   localparam logic [2:0] CSR_RESET_REPEAT = 3'd7;

   localparam int         FRAME_BITS  = 12;
   localparam logic [3:0] FRAME_COUNT = 4'd12;
   localparam logic [3:0] RUN_MAX     = 4'd15;

   typedef enum logic [2:0] {
      PH_WAIT        = 3'd0,
      PH_START_MARK  = 3'd1,
      PH_START_SPACE = 3'd2,
      PH_DATA_MARK   = 3'd3,
      PH_DATA_SPACE  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [1:0]  func;
      logic        line_level;
      logic [15:0] pulse_width;
      logic [31:0] time_stamp;
   } req_type;

   typedef struct packed {
      logic       key_valid;
      logic [4:0] device_id;
      logic [6:0] key_code;
      logic [4:0] queue_count;
      logic       frame_pushed;
      logic       reset_request;
   } rsp_type;

   // n - t <= w <= n + t, lower bound clamped at zero, no wrap
   function automatic logic in_window(logic [15:0] w, logic [15:0] n, logic [15:0] t);
      logic [16:0] lo;
      logic [16:0] hi;
      lo = (n >= t) ? {1'b0, n - t} : 17'd0;
      hi = {1'b0, n} + {1'b0, t};
      return ({1'b0, w} >= lo) && ({1'b0, w} <= hi);
   endfunction

endpackage

@@ sv/sircs_ir_frame_decoder.sv @@
// The response beat is presented in the cycle after its request beat is taken.
// Throughput: one request per clock unless a response is stalled; the key queue is a
// memory with a registered read port, the head read in the same cycle a pop is taken.
// Reset (synchronous, active high) restores the timing registers to their
// defaults, idles the decoder, empties the queue; queue contents are not cleared.
module sircs_ir_frame_decoder
   import sircs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
   localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);

   // configuration
   logic [15:0] start_mark_ff, space_ff, one_mark_ff, zero_mark_ff, tol_ff;
   logic [31:0] interkey_ff;
   logic [6:0]  reset_key_ff;
   logic [3:0]  reset_repeat_ff;

   // decoder and queue state
   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [31:0] last_push_ff, last_push_in;
   logic [3:0]  run_ff, run_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [FW-1:0] fill_ff, fill_in;

   logic [FRAME_BITS-1:0] key_mem [QUEUE_DEPTH];
   logic [FRAME_BITS-1:0] rd_data_ff;

   logic        rsp_valid_ff;
   logic        key_valid_ff;
   logic [4:0]  queue_count_ff;
   logic        pushed_ff, rreq_ff;

   logic        req_fire;
   logic        is_edge, is_pop, is_flush;
   logic        lvl;
   logic        start_ok, space_ok, one_ok, zero_ok;
   logic        complete, gap_ok, push, pop_ok, rreq;
   logic [3:0]  run_inc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign is_edge  = (req_data.func == FUNC_EDGE);
   assign is_pop   = (req_data.func == FUNC_POP);
   assign is_flush = (req_data.func == FUNC_FLUSH);
   assign lvl      = req_data.line_level;

   assign start_ok = in_window(req_data.pulse_width, start_mark_ff, tol_ff);
   assign space_ok = in_window(req_data.pulse_width, space_ff, tol_ff);
   assign one_ok   = in_window(req_data.pulse_width, one_mark_ff, tol_ff);
   assign zero_ok  = in_window(req_data.pulse_width, zero_mark_ff, tol_ff);

   // the edge after the twelfth bit's mark closes the frame whatever it looks like
   assign complete = is_edge && (phase_ff == PH_DATA_SPACE) && (bit_count_ff == FRAME_COUNT);
   assign gap_ok   = (req_data.time_stamp - last_push_ff) >= interkey_ff;
   assign push     = complete && gap_ok && (fill_ff < FILL_MAX);
   assign pop_ok   = is_pop && (fill_ff != '0);
   assign run_inc  = (run_ff == RUN_MAX) ? run_ff : run_ff + 4'd1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_edge) begin
         unique case (phase_ff)
            PH_START_MARK:  phase_in = (lvl && start_ok) ? PH_START_SPACE : PH_WAIT;
            PH_START_SPACE: phase_in = (!lvl && space_ok) ? PH_DATA_MARK : PH_WAIT;
            PH_DATA_MARK:   phase_in = (lvl && (one_ok || zero_ok)) ? PH_DATA_SPACE : PH_WAIT;
            PH_DATA_SPACE: begin
               if (bit_count_ff == FRAME_COUNT) phase_in = PH_WAIT;
               else phase_in = (!lvl && space_ok) ? PH_DATA_MARK : PH_WAIT;
            end
            default:        phase_in = lvl ? PH_WAIT : PH_START_MARK;
         endcase
      end
   end

   // decoder datapath
   always_comb begin
      shift_in     = shift_ff;
      bit_count_in = bit_count_ff;
      last_push_in = last_push_ff;
      run_in       = run_ff;
      rreq         = 1'b0;
      if (is_edge) begin
         unique case (phase_ff)
            PH_START_MARK: begin
               if (!(lvl && start_ok)) begin
                  shift_in     = '0;
                  bit_count_in = '0;
               end
            end
            PH_START_SPACE: begin
               if (!(!lvl && space_ok)) begin
                  shift_in     = '0;
                  bit_count_in = '0;
               end
            end
            PH_DATA_MARK: begin
               if (lvl && (one_ok || zero_ok)) begin
                  if (one_ok) shift_in = shift_ff | {1'b1, {(FRAME_BITS-1){1'b0}}};
                  bit_count_in = bit_count_ff + 4'd1;
               end else begin
                  shift_in     = '0;
                  bit_count_in = '0;
               end
            end
            PH_DATA_SPACE: begin
               if (bit_count_ff == FRAME_COUNT) begin
                  if (gap_ok) begin
                     last_push_in = req_data.time_stamp;
                     if (shift_ff[6:0] == reset_key_ff) begin
                        run_in = run_inc;
                        if ((reset_repeat_ff != '0) && (run_inc == reset_repeat_ff)) begin
                           rreq   = 1'b1;
                           run_in = '0;
                        end
                     end else begin
                        run_in = '0;
                     end
                  end
                  shift_in     = '0;
                  bit_count_in = '0;
               end else if (!lvl && space_ok) begin
                  shift_in = shift_ff >> 1;
               end else begin
                  shift_in     = '0;
                  bit_count_in = '0;
               end
            end
            default: begin
               if (lvl) begin
                  shift_in     = '0;
                  bit_count_in = '0;
               end
            end
         endcase
      end
   end

   // queue pointers and fill
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
         fill_in   = fill_ff + FW'(1);
      end else if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
         fill_in   = fill_ff - FW'(1);
      end else if (is_flush) begin
         rd_ptr_in = wr_ptr_ff;
         fill_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_mark_ff   <= 16'd2400;
         space_ff        <= 16'd600;
         one_mark_ff     <= 16'd1200;
         zero_mark_ff    <= 16'd600;
         tol_ff          <= 16'd200;
         interkey_ff     <= '0;
         reset_key_ff    <= '0;
         reset_repeat_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_MARK:   start_mark_ff   <= csr_wdata[15:0];
            CSR_SPACE:        space_ff        <= csr_wdata[15:0];
            CSR_ONE_MARK:     one_mark_ff     <= csr_wdata[15:0];
            CSR_ZERO_MARK:    zero_mark_ff    <= csr_wdata[15:0];
            CSR_TOLERANCE:    tol_ff          <= csr_wdata[15:0];
            CSR_INTERKEY:     interkey_ff     <= csr_wdata;
            CSR_RESET_KEY:    reset_key_ff    <= csr_wdata[6:0];
            CSR_RESET_REPEAT: reset_repeat_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         last_push_ff <= '0;
         run_ff       <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff     <= phase_in;
            bit_count_ff <= bit_count_in;
            shift_ff     <= shift_in;
            last_push_ff <= last_push_in;
            run_ff       <= run_in;
            rd_ptr_ff    <= rd_ptr_in;
            wr_ptr_ff    <= wr_ptr_in;
            fill_ff      <= fill_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, held while the beat is stalled
   always_ff @(posedge clock) begin
      if (req_fire) begin
         key_valid_ff   <= pop_ok;
         queue_count_ff <= 5'(fill_in);
         pushed_ff      <= push;
         rreq_ff        <= rreq;
      end
   end

   // key queue: write on push, registered read of the head on pop
   always_ff @(posedge clock) begin
      if (req_fire && push) key_mem[wr_ptr_ff] <= shift_ff;
      if (req_fire && pop_ok) rd_data_ff <= key_mem[rd_ptr_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   // fields in struct order: key_valid, device_id, key_code, queue_count,
   // frame_pushed, reset_request
   assign rsp_data  = {key_valid_ff,
                       key_valid_ff ? rd_data_ff[11:7] : 5'd0,
                       key_valid_ff ? rd_data_ff[6:0] : 7'd0,
                       queue_count_ff,
                       pushed_ff,
                       rreq_ff};

endmodule
